### design/mqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_pkg
// Shared types and constants of the max-weight queens search core.
// ----------------------------------------------------------------------------
package mqs_pkg;

	localparam int ROW_W       = 3;
	localparam int WEIGHT_IN_W = 8;
	localparam int SCORE_W     = 11;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 11'h7ff;

	// Command from the sequencer to the occupancy tracker
	typedef struct packed {
		logic clear;
		logic toggle;
	} occ_cmd_t;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_PLACE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

### design/mqs_occupancy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_occupancy
// Column, rising-diagonal and falling-diagonal occupancy bitmaps with one
// attack check port, one toggle port and a clear command.
// ----------------------------------------------------------------------------
module mqs_occupancy #(
	parameter int BOARD_SIZE = 8,
	localparam int IDX_W = (BOARD_SIZE > 1) ? $clog2(BOARD_SIZE) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mqs_pkg::occ_cmd_t cmd,
	input  logic [IDX_W-1:0]  chk_row,
	input  logic [IDX_W-1:0]  chk_col,
	input  logic [IDX_W-1:0]  tgl_row,
	input  logic [IDX_W-1:0]  tgl_col,
	output logic              free
);
	import mqs_pkg::*;

	localparam int DIAG = 2 * BOARD_SIZE - 1;
	localparam int DW   = (DIAG > 1) ? $clog2(DIAG) : 1;

	logic [BOARD_SIZE-1:0] col_q;
	logic [DIAG-1:0]       rise_q;
	logic [DIAG-1:0]       fall_q;

	logic [DW-1:0] chk_rise, chk_fall, tgl_rise, tgl_fall;

	// falling diagonal index: row + (N-1) - col, never negative
	assign chk_rise = DW'(chk_row) + DW'(chk_col);
	assign chk_fall = DW'(chk_row) + DW'(BOARD_SIZE - 1) - DW'(chk_col);
	assign tgl_rise = DW'(tgl_row) + DW'(tgl_col);
	assign tgl_fall = DW'(tgl_row) + DW'(BOARD_SIZE - 1) - DW'(tgl_col);

	assign free = !col_q[chk_col] && !rise_q[chk_rise] && !fall_q[chk_fall];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rise_q <= '0;
			fall_q <= '0;
		end else if (cmd.clear) begin
			col_q  <= '0;
			rise_q <= '0;
			fall_q <= '0;
		end else if (cmd.toggle) begin
			col_q[tgl_col]   <= ~col_q[tgl_col];
			rise_q[tgl_rise] <= ~rise_q[tgl_rise];
			fall_q[tgl_fall] <= ~fall_q[tgl_fall];
		end
	end

endmodule

### design/max_weight_queens_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_weight_queens_search_core
// Loads an N by N weight board and finds the heaviest non-attacking placement
// of N queens by iterative backtracking.
// ----------------------------------------------------------------------------
// Squares load at one per cycle into an on-chip weight memory while
// square_ready is high; off-board squares are dropped. The transfer marked
// last starts the search, during which square_ready is low. The search steps
// one candidate column per cycle through a single attack check, except where
// a free square enters the placement state, in which the registered weight
// memory read feeds the shared adder; a backtrack takes a scan step of its
// own. The search is exhaustive, so its running time does not depend on the
// weights. A finished search waits in the done state until a previous score
// still held is taken by score_ready. Squares of the next board may load
// while the previous score still waits on score_ready.
// Scores above 2047 saturate.
// ----------------------------------------------------------------------------
module max_weight_queens_search_core #(
	parameter int BOARD_SIZE  = 8,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              square_valid,
	output logic                              square_ready,
	input  logic [mqs_pkg::ROW_W-1:0]         row,
	input  logic [mqs_pkg::ROW_W-1:0]         col,
	input  logic [mqs_pkg::WEIGHT_IN_W-1:0]   weight,
	input  logic                              last,
	output logic                              score_valid,
	input  logic                              score_ready,
	output logic [mqs_pkg::SCORE_W-1:0]       highest_score
);
	import mqs_pkg::*;

	localparam int WB      = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
	localparam int IDX_W   = (BOARD_SIZE > 1) ? $clog2(BOARD_SIZE) : 1;
	localparam int CNT_W   = $clog2(BOARD_SIZE + 1);
	localparam int SQ      = BOARD_SIZE * BOARD_SIZE;
	localparam int AW      = (SQ > 1) ? $clog2(SQ) : 1;
	localparam int SUM_MAX = BOARD_SIZE * ((1 << WB) - 1);
	localparam int SUM_W   = $clog2(SUM_MAX + 1);

	state_t state_q;

	logic [IDX_W-1:0] lvl_q;
	logic [CNT_W-1:0] c_q;
	logic [SUM_W-1:0] best_q;
	logic             score_valid_q;
	logic [SCORE_W-1:0] score_q;

	logic [WB-1:0]    weight_mem_q [SQ];
	logic [WB-1:0]    rd_q;
	logic [IDX_W-1:0] queen_q   [BOARD_SIZE];
	logic [SUM_W-1:0] partial_q [BOARD_SIZE];

	logic             accept;
	logic             on_board;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [IDX_W-1:0] c_idx;
	logic             col_end;
	logic             free;
	logic [IDX_W-1:0] prev_lvl;
	logic [IDX_W-1:0] prev_col;
	logic [SUM_W-1:0] sum;
	logic [31:0]      best_wide;
	occ_cmd_t         occ_cmd;
	logic [IDX_W-1:0] tgl_row, tgl_col;

	assign square_ready  = (state_q == ST_LOAD);
	assign accept        = square_valid && square_ready;
	assign score_valid   = score_valid_q;
	assign highest_score = score_q;

	assign on_board = (32'(row) < BOARD_SIZE) && (32'(col) < BOARD_SIZE);
	assign wr_addr  = AW'(row) * AW'(BOARD_SIZE) + AW'(col);
	assign c_idx    = c_q[IDX_W-1:0];
	assign rd_addr  = AW'(lvl_q) * AW'(BOARD_SIZE) + AW'(c_idx);
	assign col_end  = (c_q == CNT_W'(BOARD_SIZE));
	assign prev_lvl = lvl_q - IDX_W'(1);
	assign prev_col = queen_q[prev_lvl];
	assign sum      = partial_q[lvl_q] + SUM_W'(rd_q);
	assign best_wide = 32'(best_q);

	// Occupancy updates: clear on search start, set on placement, undo on backtrack
	always_comb begin
		occ_cmd = '0;
		tgl_row = lvl_q;
		tgl_col = c_idx;
		case (state_q)
			ST_LOAD: begin
				occ_cmd.clear = accept && last;
			end
			ST_SCAN: begin
				if (col_end && lvl_q != '0) begin
					occ_cmd.toggle = 1'b1;
					tgl_row        = prev_lvl;
					tgl_col        = prev_col;
				end
			end
			ST_PLACE: begin
				// the leaf row is scored without marking it
				occ_cmd.toggle = (32'(lvl_q) != BOARD_SIZE - 1);
			end
			default: begin
				occ_cmd = '0;
			end
		endcase
	end

	mqs_occupancy #(
		.BOARD_SIZE(BOARD_SIZE)
	) u_occ (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (occ_cmd),
		.chk_row (lvl_q),
		.chk_col (c_idx),
		.tgl_row (tgl_row),
		.tgl_col (tgl_col),
		.free    (free)
	);

	always_ff @(posedge clk) begin
		if (accept && on_board) begin
			weight_mem_q[wr_addr] <= weight[WB-1:0];
		end
		if (state_q == ST_SCAN && !col_end && free) begin
			rd_q <= weight_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			partial_q[0] <= '0;
		end
		if (state_q == ST_PLACE && 32'(lvl_q) != BOARD_SIZE - 1) begin
			partial_q[lvl_q + IDX_W'(1)] <= sum;
			queen_q[lvl_q]               <= c_idx;
		end
		if (state_q == ST_DONE && (!score_valid_q || score_ready)) begin
			score_q <= (best_wide > 32'(SCORE_MAX)) ? SCORE_MAX : best_wide[SCORE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			lvl_q         <= '0;
			c_q           <= '0;
			best_q        <= '0;
			score_valid_q <= 1'b0;
		end else begin
			// in ST_DONE the new score takes the slot of the one leaving
			if (score_valid_q && score_ready && state_q != ST_DONE) begin
				score_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept && last) begin
						lvl_q   <= '0;
						c_q     <= '0;
						best_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (col_end) begin
						if (lvl_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							lvl_q <= prev_lvl;
							c_q   <= CNT_W'(prev_col) + CNT_W'(1);
						end
					end else if (free) begin
						state_q <= ST_PLACE;
					end else begin
						c_q <= c_q + CNT_W'(1);
					end
				end
				ST_PLACE: begin
					if (32'(lvl_q) == BOARD_SIZE - 1) begin
						if (sum > best_q) begin
							best_q <= sum;
						end
						c_q <= c_q + CNT_W'(1);
					end else begin
						lvl_q <= lvl_q + IDX_W'(1);
						c_q   <= '0;
					end
					state_q <= ST_SCAN;
				end
				ST_DONE: begin
					if (!score_valid_q || score_ready) begin
						score_valid_q <= 1'b1;
						state_q       <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// a placement always follows a successful column check
	a_place_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PLACE |-> $past(state_q) == ST_SCAN)
		else $error("placement without a preceding column check");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(c_q) <= BOARD_SIZE)
		else $error("column counter beyond board");

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(lvl_q) < BOARD_SIZE)
		else $error("search level beyond board");

	a_score_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(score_valid) |-> $past(state_q) == ST_DONE)
		else $error("score raised outside search completion");

	a_no_load_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_PLACE) |-> !square_ready)
		else $error("square accepted during search");

endmodule
